// ===== design/qwdds_pkg.sv =====
// ----------------------------------------------------------------------------
// qwdds_pkg
// Shared types, constants and the quarter-wave sine table generator for the
// two-channel quarter-wave sine synthesizer.
// ----------------------------------------------------------------------------
package qwdds_pkg;

  // sample format
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned AMPL       = 2047;
  localparam int unsigned FULL_SCALE = 4095;

  // configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // pi in unsigned q60 fixed point
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TUNING_CH0 = 2'd0,
    REG_TUNING_CH1 = 2'd1,
    REG_START_CH0  = 2'd2,
    REG_START_CH1  = 2'd3
  } cfg_reg_t;

  // (a * b) >> 60 for q60 operands below 2^62
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh;
    logic [63:0] ll, lh, hl, hh;
    logic [63:0] mid, lo, hi;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
    return {hi[59:0], lo[63:60]};
  endfunction

  // floor(2047*sin(x) + 2047) for table entry i, taylor series in q60,
  // evaluated at elaboration only
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned i,
                                                     input int unsigned index_bits);
    logic [63:0] step, x, x2, term, sum, q, r, v;
    step = PI_Q60 >> (index_bits - 1);
    x    = step * 64'(i);
    x2   = qmul(x, x);
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 14; n++) begin
      term = qmul(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = sum >> 30;
    r = sum & 64'h3FFF_FFFF;
    v = (64'(AMPL) * q + ((64'(AMPL) * r) >> 30)) >> 30;
    return SAMPLE_W'(v + 64'(AMPL));
  endfunction

endpackage

// ===== design/qwdds_if.sv =====
// ----------------------------------------------------------------------------
// qwdds_in_if / qwdds_out_if
// Valid/ready channels of the quarter-wave sine synthesizer: sample request
// words in, sample words out.
// ----------------------------------------------------------------------------
interface qwdds_in_if;
  logic valid;
  logic ready;
  logic channel;
  logic restart;

  modport source (output valid, output channel, output restart, input ready);
  modport sink   (input valid, input channel, input restart, output ready);
endinterface

interface qwdds_out_if;
  logic                          valid;
  logic                          ready;
  logic [qwdds_pkg::SAMPLE_W-1:0] sample;
  logic                          sample_channel;

  modport source (output valid, output sample, output sample_channel, input ready);
  modport sink   (input valid, input sample, input sample_channel, output ready);
endinterface

// ===== design/qwdds_rom.sv =====
// ----------------------------------------------------------------------------
// qwdds_rom
// Generic read-only memory, contents fixed at build, one registered read port
// with a read enable that holds the output word while low.
// ----------------------------------------------------------------------------
module qwdds_rom #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2049,
  localparam int ADDR_W = $clog2(DEPTH),
  parameter logic [WIDTH-1:0] INIT [DEPTH] = '{default: '0}
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= INIT[rd_addr];
    end
  end

endmodule

// ===== design/quarter_wave_dds_sine.sv =====
// ----------------------------------------------------------------------------
// quarter_wave_dds_sine
// Two-channel direct digital synthesizer with a quarter-wave sine table.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : request words {channel, restart}. restart uses the channel's
//            start phase in place of its accumulator for this sample.
//   out_if : sample words {sample, sample_channel}, 12-bit offset binary,
//            midscale 2047.
//   cfg_*  : write port for tuning words (index 0, 1) and start phases
//            (index 2, 3). Write only while no request is in flight.
// Timing:
//   a request accepted at an edge is registered in the table-read stage, then
//   in the output register, and shows on out_if from there.
//   One request per cycle is taken while out_if is not stalled; the per-channel
//   accumulator add feeds back through its own register, and the table read
//   goes through the registered port of the table memory. A stalled output holds
//   its word, and one more request is still taken into the table-read stage.
// Reset:
//   accumulators clear to zero, tuning words to 4294, start phases to zero,
//   both pipeline stages empty. The table is fixed at build.
// ----------------------------------------------------------------------------
module quarter_wave_dds_sine #(
  parameter int PHASE_BITS = 32,
  parameter int INDEX_BITS = 13,
  parameter int CHANNELS   = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  qwdds_in_if.sink                            in_if,
  qwdds_out_if.source                         out_if,
  input  logic                                cfg_we,
  input  logic [qwdds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qwdds_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import qwdds_pkg::*;

  localparam int QTR       = 1 << (INDEX_BITS - 2);
  localparam int TABLE_LEN = QTR + 1;
  localparam int ADDR_W    = INDEX_BITS - 1;
  localparam int ACC_N     = (CHANNELS < 2) ? 1 : 2;

  localparam logic [INDEX_BITS:0] Q1 = (INDEX_BITS + 1)'(QTR);
  localparam logic [INDEX_BITS:0] Q2 = (INDEX_BITS + 1)'(2 * QTR);
  localparam logic [INDEX_BITS:0] Q3 = (INDEX_BITS + 1)'(3 * QTR);
  localparam logic [INDEX_BITS:0] Q4 = (INDEX_BITS + 1)'(4 * QTR);

  typedef logic [SAMPLE_W-1:0] qtab_t [TABLE_LEN];

  // quarter-wave table contents, last entry is the exact peak
  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QTR; i++) begin
      t[i] = sine_entry(i, INDEX_BITS);
    end
    t[QTR] = SAMPLE_W'(2 * AMPL);
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [CFG_DATA_W-1:0] tuning_r [2];
  logic [CFG_DATA_W-1:0] start_r  [2];
  logic [PHASE_BITS-1:0] accum_r  [ACC_N];

  logic                  sel_ch;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [PHASE_BITS-1:0] accum_nxt;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS:0]   idx_ext;
  logic [INDEX_BITS:0]   fold;
  logic [ADDR_W-1:0]     rom_addr;
  logic                  invert;
  logic [SAMPLE_W-1:0]   rom_data;

  logic                  in_fire;
  logic                  out_adv;
  logic                  s1_en;
  logic                  s1_valid_r;
  logic                  s1_invert_r;
  logic                  s1_ch_r;
  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic [SAMPLE_W-1:0]   out_sample_nxt;
  logic                  out_ch_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuning_r[0] <= CFG_DATA_W'(4294);
      tuning_r[1] <= CFG_DATA_W'(4294);
      start_r[0]  <= '0;
      start_r[1]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TUNING_CH0: tuning_r[0] <= cfg_wdata;
        REG_TUNING_CH1: tuning_r[1] <= cfg_wdata;
        REG_START_CH0:  start_r[0]  <= cfg_wdata;
        REG_START_CH1:  start_r[1]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: output stage frees when empty or taken, table stage likewise
  assign out_adv     = !out_valid_r || out_if.ready;
  assign s1_en       = !s1_valid_r || out_adv;
  assign in_if.ready = s1_en;
  assign in_fire     = in_if.valid && s1_en;

  // channel select saturates to the last channel
  assign sel_ch = (CHANNELS < 2) ? 1'b0 : in_if.channel;

  // phase for this sample, then the accumulator step
  always_comb begin
    if (in_if.restart) begin
      cur_phase = PHASE_BITS'(start_r[sel_ch]);
    end else begin
      cur_phase = accum_r[(ACC_N > 1) ? sel_ch : 1'b0];
    end
    accum_nxt = cur_phase + PHASE_BITS'(tuning_r[sel_ch]);
  end

  // fold the full-period index onto the quarter table
  assign idx     = cur_phase[PHASE_BITS-1 -: INDEX_BITS];
  assign idx_ext = {1'b0, idx};

  always_comb begin
    if (idx_ext <= Q1) begin
      fold   = idx_ext;
      invert = 1'b0;
    end else if (idx_ext <= Q2) begin
      fold   = Q2 - idx_ext;
      invert = 1'b0;
    end else if (idx_ext <= Q3) begin
      fold   = idx_ext - Q2;
      invert = 1'b1;
    end else begin
      fold   = Q4 - idx_ext;
      invert = 1'b1;
    end
  end

  assign rom_addr = fold[ADDR_W-1:0];

  // phase accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < ACC_N; c++) begin
        accum_r[c] <= '0;
      end
    end else if (in_fire) begin
      accum_r[(ACC_N > 1) ? sel_ch : 1'b0] <= accum_nxt;
    end
  end

  // quarter-wave table
  qwdds_rom #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_LEN),
    .INIT  (QTAB)
  ) u_table (
    .clk     (clk),
    .rd_en   (s1_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // table-read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_invert_r <= invert;
      s1_ch_r     <= sel_ch;
    end
  end

  // lower half of the period is the inverted entry
  assign out_sample_nxt = s1_invert_r ? (SAMPLE_W'(FULL_SCALE) - rom_data) : rom_data;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_sample_r <= out_sample_nxt;
      out_ch_r     <= s1_ch_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.sample         = out_sample_r;
  assign out_if.sample_channel = out_ch_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-channel quarter-wave sine synthesizer.
// Drives sample requests with random gaps, stalls the sample output at
// random, predicts every sample from its own phase accumulators and sine
// table, and compares each output word field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import qwdds_pkg::*;

  localparam int          CLK_HALF_NS = 6;
  localparam int          TIMEOUT_NS  = 3_000_000;
  localparam int          PHASE_W     = 32;
  localparam int          INDEX_W     = 13;
  localparam int          QUARTER     = 2048;
  localparam int          HALF        = 4096;
  localparam int          THREE_Q     = 6144;
  localparam int          FULL_TURN   = 8192;
  localparam int          PIPE_SLACK  = 6;
  localparam logic [31:0] PHASE_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                channel;
  } sample_word_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  qwdds_in_if  req_ch ();
  qwdds_out_if smp_ch ();

  quarter_wave_dds_sine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (smp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [SAMPLE_W-1:0] sine_quarter [0:QUARTER];
  logic [PHASE_W-1:0]  phase_acc [2];
  logic [PHASE_W-1:0]  tuning [2];
  logic [PHASE_W-1:0]  start_phase [2];
  sample_word_t        expected_samples [$];

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF_NS) clk = ~clk;

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // q60 product, bits 60 and up of the full product
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // floor(2047*sin(angle)+2047) by taylor series in q60
  function automatic logic [SAMPLE_W-1:0] sine_point(input int unsigned i);
    logic [63:0] ang, ang_sq, term, acc, whole, frac, scaled;
    ang    = (PI_Q60 >> (INDEX_W - 1)) * 64'(i);
    ang_sq = q60_mul(ang, ang);
    term   = ang;
    acc    = ang;
    for (int unsigned n = 1; n <= 14; n++) begin
      term = q60_mul(term, ang_sq) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    whole  = acc >> 30;
    frac   = acc & 64'h3FFF_FFFF;
    scaled = (64'(AMPL) * whole + ((64'(AMPL) * frac) >> 30)) >> 30;
    return SAMPLE_W'(scaled + 64'(AMPL));
  endfunction

  // fold a full-period index onto the quarter table
  function automatic logic [SAMPLE_W-1:0] fold_sine(input int idx);
    if (idx <= QUARTER) begin
      return sine_quarter[idx];
    end else if (idx <= HALF) begin
      return sine_quarter[HALF - idx];
    end else if (idx <= THREE_Q) begin
      return SAMPLE_W'(FULL_SCALE) - sine_quarter[idx - HALF];
    end else begin
      return SAMPLE_W'(FULL_SCALE) - sine_quarter[FULL_TURN - idx];
    end
  endfunction

  // next sample of a channel, advances that channel's accumulator
  function automatic sample_word_t next_sine_sample(input logic ch, input logic reload);
    sample_word_t w;
    if (reload) begin
      phase_acc[ch] = start_phase[ch];
    end
    w.sample  = fold_sine(int'(phase_acc[ch] >> (PHASE_W - INDEX_W)));
    w.channel = ch;
    phase_acc[ch] = phase_acc[ch] + tuning[ch];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // one request word, called and returning at a falling edge
  task automatic send_request(input logic ch, input logic reload);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.channel = ch;
    req_ch.restart = reload;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    expected_samples.push_back(next_sine_sample(ch, reload));
    @(negedge clk);
  endtask

  // wait until every sample is out and the pipe is empty
  task automatic drain_samples();
    req_ch.valid = 1'b0;
    while (expected_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TUNING_CH0: tuning[0]      = value;
      REG_TUNING_CH1: tuning[1]      = value;
      REG_START_CH0:  start_phase[0] = value;
      REG_START_CH1:  start_phase[1] = value;
      default: ;
    endcase
  endtask

  // extremes, small steps, table-aligned steps and random words
  function automatic logic [31:0] pick_phase_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return PHASE_MAX;
      2: return 32'($urandom_range(1, 1 << 18));
      3: return 32'($urandom_range(FULL_TURN - 1)) << (PHASE_W - INDEX_W);
      4: return PHASE_MAX - 32'($urandom_range(1 << 20));
      default: return $urandom();
    endcase
  endfunction

  // defaults after reset: tuning 4294, start phases zero
  task automatic test_reset_state();
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b1);
    drain_samples();
  endtask

  // quadrant edges, index mirror points and accumulator wrap
  task automatic test_quadrant_edges();
    write_register(REG_TUNING_CH0, 32'h4000_0000);
    write_register(REG_START_CH0, 32'd0);
    write_register(REG_TUNING_CH1, 32'h0008_0000);
    write_register(REG_START_CH1, 32'h3FF0_0000);
    send_request(1'b0, 1'b1);
    repeat (4) send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b1);
    repeat (3) send_request(1'b1, 1'b0);
    drain_samples();
    // around the half and three-quarter points
    write_register(REG_TUNING_CH0, 32'h0008_0000);
    write_register(REG_START_CH0, 32'h7FF8_0000);
    write_register(REG_START_CH1, 32'hBFF8_0000);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b0);
    drain_samples();
    // all-ones phase and step, wraps every sample
    write_register(REG_TUNING_CH0, PHASE_MAX);
    write_register(REG_START_CH0, PHASE_MAX);
    write_register(REG_TUNING_CH1, 32'd0);
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    drain_samples();
  endtask

  // random requests in several register settings at one idle mix
  task automatic test_random_stream(input int n_items, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int seg = 0; seg < 3; seg++) begin
      write_register(REG_TUNING_CH0, pick_phase_word());
      write_register(REG_TUNING_CH1, pick_phase_word());
      write_register(REG_START_CH0, pick_phase_word());
      write_register(REG_START_CH1, pick_phase_word());
      for (int k = 0; k < n_items / 3; k++) begin
        send_request(1'($urandom_range(1)), ($urandom_range(7) == 0));
        // sender holds off until the output side has caught up
        if ($urandom_range(49) == 0) begin
          drain_samples();
        end
      end
      drain_samples();
    end
  endtask

  // output check, oldest expectation first
  always @(posedge clk) begin
    sample_word_t want;
    if (rst_n && smp_ch.valid && smp_ch.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample word", int'(smp_ch.sample), -1);
      end else begin
        want = expected_samples.pop_front();
        if (smp_ch.sample !== want.sample) begin
          report_mismatch("sample", int'(smp_ch.sample), int'(want.sample));
        end
        if (smp_ch.sample_channel !== want.channel) begin
          report_mismatch("sample_channel", int'(smp_ch.sample_channel), int'(want.channel));
        end
      end
    end
  end

  // output stall pattern
  always @(negedge clk) begin
    smp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_TUNING_CH0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.channel = 1'b0;
    req_ch.restart = 1'b0;
    smp_ch.ready   = 1'b0;
    error_count    = 0;
    send_idle_pct  = 27;
    recv_idle_pct  = 69;
    for (int i = 0; i < QUARTER; i++) begin
      sine_quarter[i] = sine_point(i);
    end
    sine_quarter[QUARTER] = SAMPLE_W'(2 * AMPL);
    for (int c = 0; c < 2; c++) begin
      phase_acc[c]   = '0;
      tuning[c]      = 32'd4294;
      start_phase[c] = '0;
    end

    // synchronous reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_quadrant_edges();
    test_random_stream(135, 27, 69);
    test_random_stream(135, 69, 27);
    test_random_stream(135, 0, 0);

    drain_samples();
    repeat (PIPE_SLACK) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== quarter_wave_dds_sine.f =====
design/qwdds_pkg.sv
design/qwdds_if.sv
design/qwdds_rom.sv
design/quarter_wave_dds_sine.sv
tb/sv/tb.sv
